/* design/erd_pkg.sv */
// Shared types, constants and saturating arithmetic for the reaction-diffusion step.
// Depends on nothing; every other file of the block imports it.
package erd_pkg;

    // Number format: signed fixed point, Q8.24.
    localparam int WORD_BITS      = 32;
    localparam int FRAC_BITS      = 24;
    localparam int PROD_BITS      = 2 * WORD_BITS;
    localparam int CFG_BITS       = 32;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t FIX_ONE  = word_t'(64'd1 << FRAC_BITS);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_TIME_STEP        = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_GAIN       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HISTORY_COUPLING = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INV_DX_SQ        = 2'd3;

    // Configuration reset values.
    localparam word_t RST_TIME_STEP        = 32'sd1677722;
    localparam word_t RST_DECAY_GAIN       = -32'sd10569646;
    localparam word_t RST_HISTORY_COUPLING = 32'sd0;
    localparam word_t RST_INV_DX_SQ        = 32'sd4194304;

    // Configuration as seen by the datapath, every value already a word.
    typedef struct packed {
        word_t time_step;
        word_t decay_gain;
        word_t history_coupling;
        word_t inv_dx_sq;
    } cfg_t;

    // One site update: the three-site window plus history and row end.
    typedef struct packed {
        word_t left_density;
        word_t center_density;
        word_t center_history;
        word_t right_density;
        logic  last;
    } job_t;

    // Saturating add.
    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    // Saturating subtract.
    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    // Floor of the exact mean of two words; it always fits in a word.
    function automatic word_t floor_mean(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        return s[WORD_BITS:1];
    endfunction

endpackage

/* design/erd_job_queue.sv */
// Short first-in first-out queue of site-update jobs between front and back.
// Depends on erd_pkg for the job type.
module erd_job_queue
    import erd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_en,
    input  job_t push_job,
    output logic full,
    input  logic pop_en,
    output job_t head_job,
    output logic empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t               store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = store_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_en && !pop_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_en && !push_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* design/erd_front.sv */
// Front end: accepts sites, keeps the three-site window and issues update jobs.
// Depends on erd_pkg for the word and job types.
module erd_front
    import erd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  word_t site_density,
    input  word_t site_history,
    input  logic  last_site,
    input  logic  q_full,
    output logic  q_push,
    output job_t  q_job
);

    word_t left_reg,    left_next;
    word_t center_reg,  center_next;
    word_t history_reg, history_next;
    logic  held_reg,    held_next;
    logic  pend_valid_reg, pend_valid_next;
    job_t  pend_job_reg,   pend_job_next;

    job_t  held_job;
    job_t  last_job;
    logic  accept;

    // A pending second job blocks new sites until it is queued.
    assign full   = q_full || pend_valid_reg;
    assign accept = push && !full;

    // Job for the held site, whose right neighbour is the new site.
    assign held_job = '{left_density:   left_reg,
                        center_density: center_reg,
                        center_history: history_reg,
                        right_density:  site_density,
                        last:           1'b0};

    // Job for a last site, whose right neighbour is beyond the row end.
    assign last_job = '{left_density:   held_reg ? center_reg : '0,
                        center_density: site_density,
                        center_history: site_history,
                        right_density:  '0,
                        last:           1'b1};

    // Window update and job issue.
    always_comb
    begin
        left_next       = left_reg;
        center_next     = center_reg;
        history_next    = history_reg;
        held_next       = held_reg;
        pend_valid_next = pend_valid_reg;
        pend_job_next   = pend_job_reg;
        q_push          = 1'b0;
        q_job           = pend_job_reg;

        if (pend_valid_reg && !q_full)
        begin
            q_push          = 1'b1;
            pend_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (held_reg)
            begin
                q_push = 1'b1;
                q_job  = held_job;
                if (last_site)
                begin
                    pend_valid_next = 1'b1;
                    pend_job_next   = last_job;
                end
            end
            else if (last_site)
            begin
                q_push = 1'b1;
                q_job  = last_job;
            end

            if (last_site)
            begin
                left_next    = '0;
                center_next  = '0;
                history_next = '0;
                held_next    = 1'b0;
            end
            else
            begin
                left_next    = held_reg ? center_reg : '0;
                center_next  = site_density;
                history_next = site_history;
                held_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            center_reg     <= '0;
            history_reg    <= '0;
            held_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg       <= left_next;
            center_reg     <= center_next;
            history_reg    <= history_next;
            held_reg       <= held_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_job_reg <= pend_job_next;
    end

endmodule

/* design/erd_mul.sv */
// Shared fixed-point multiplier: two-stage, floors toward minus infinity, saturates.
// Depends on erd_pkg for the word type and format constants.
module erd_mul
    import erd_pkg::*;
(
    input  logic  clk,
    input  word_t op_a,
    input  word_t op_b,
    output word_t product
);

    localparam int Q_BITS = PROD_BITS - FRAC_BITS + 1;

    logic [WORD_BITS-1:0] ua, ub, mag_a, mag_b;
    logic [PROD_BITS-1:0] prod_reg, prod_next;
    logic                 neg_reg, neg_next;
    logic [Q_BITS-1:0]    quot;
    logic                 inexact;
    word_t                res_reg, res_next;

    // First stage: magnitude product and sign.
    always_comb
    begin
        ua        = op_a;
        ub        = op_b;
        mag_a     = ua[WORD_BITS-1] ? (~ua + {{(WORD_BITS-1){1'b0}}, 1'b1}) : ua;
        mag_b     = ub[WORD_BITS-1] ? (~ub + {{(WORD_BITS-1){1'b0}}, 1'b1}) : ub;
        prod_next = mag_a * mag_b;
        neg_next  = ua[WORD_BITS-1] ^ ub[WORD_BITS-1];
    end

    // Second stage: drop fraction bits, round a negative result down, saturate.
    always_comb
    begin
        inexact = |prod_reg[FRAC_BITS-1:0];
        quot    = {1'b0, prod_reg[PROD_BITS-1:FRAC_BITS]}
                  + Q_BITS'(neg_reg && inexact);
        if (!neg_reg)
        begin
            if (|quot[Q_BITS-1:WORD_BITS-1])
                res_next = WORD_MAX;
            else
                res_next = quot[WORD_BITS-1:0];
        end
        else
        begin
            if ((|quot[Q_BITS-1:WORD_BITS]) ||
                (quot[WORD_BITS-1] && (|quot[WORD_BITS-2:0])))
                res_next = WORD_MIN;
            else
                res_next = word_t'(~quot[WORD_BITS-1:0]) + word_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
    end

    assign product = res_reg;

endmodule

/* design/erd_back.sv */
// Back end: sequences one site update through the shared multiplier and holds the result.
// Depends on erd_pkg and erd_mul.
module erd_back
    import erd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  job_empty,
    input  job_t  job,
    output logic  job_pop,
    output logic  empty,
    input  logic  pop,
    output word_t new_density,
    output word_t new_history,
    output logic  last_out
);

    // Sequencer steps; a product is used once it has passed both multiplier registers.
    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_BH        = 5'd1;
    localparam logic [4:0] ST_LAP       = 5'd2;
    localparam logic [4:0] ST_DIFF      = 5'd3;
    localparam logic [4:0] ST_GAIN      = 5'd4;
    localparam logic [4:0] ST_SQ        = 5'd5;
    localparam logic [4:0] ST_GROW_PREP = 5'd6;
    localparam logic [4:0] ST_GROW      = 5'd7;
    localparam logic [4:0] ST_GROW_WAIT = 5'd8;
    localparam logic [4:0] ST_DP_SUM    = 5'd9;
    localparam logic [4:0] ST_DP_SUB    = 5'd10;
    localparam logic [4:0] ST_DT        = 5'd11;
    localparam logic [4:0] ST_DT_WAIT   = 5'd12;
    localparam logic [4:0] ST_NP        = 5'd13;
    localparam logic [4:0] ST_AVG       = 5'd14;
    localparam logic [4:0] ST_HIST      = 5'd15;
    localparam logic [4:0] ST_HIST_WAIT = 5'd16;
    localparam logic [4:0] ST_DONE      = 5'd17;

    logic [4:0] state_reg, state_next;
    job_t       job_reg,   job_next;
    word_t      x_reg, x_next;
    word_t      y_reg, y_next;
    word_t      z_reg, z_next;
    logic       out_valid_reg, out_valid_next;
    word_t      out_density_reg, out_density_next;
    word_t      out_history_reg, out_history_next;
    logic       out_last_reg, out_last_next;

    word_t      mul_a, mul_b, prod;
    logic       out_free;

    erd_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    assign out_free = !out_valid_reg || pop;
    assign job_pop  = (state_reg == ST_IDLE) && !job_empty;

    // Multiplier operands per step; the last pair is held while the result stalls.
    always_comb
    begin
        unique case (state_reg)
            ST_BH:
            begin
                mul_a = cfg.history_coupling;
                mul_b = job_reg.center_history;
            end
            ST_DIFF:
            begin
                mul_a = x_reg;
                mul_b = cfg.inv_dx_sq;
            end
            ST_GAIN:
            begin
                mul_a = cfg.decay_gain;
                mul_b = y_reg;
            end
            ST_SQ:
            begin
                mul_a = job_reg.center_density;
                mul_b = job_reg.center_density;
            end
            ST_GROW:
            begin
                mul_a = y_reg;
                mul_b = job_reg.center_density;
            end
            ST_DT:
            begin
                mul_a = cfg.time_step;
                mul_b = x_reg;
            end
            default:
            begin
                mul_a = y_reg;
                mul_b = cfg.time_step;
            end
        endcase
    end

    // Sequencer and datapath.
    always_comb
    begin
        state_next       = state_reg;
        job_next         = job_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        z_next           = z_reg;
        out_valid_next   = out_valid_reg && !pop;
        out_density_next = out_density_reg;
        out_history_next = out_history_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_next   = job;
                    state_next = ST_BH;
                end
            end
            ST_BH:
            begin
                x_next     = sat_add(job_reg.left_density, job_reg.right_density);
                y_next     = sat_add(job_reg.center_density, job_reg.center_density);
                state_next = ST_LAP;
            end
            ST_LAP:
            begin
                // Laplacian of the window.
                x_next     = sat_sub(x_reg, y_reg);
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                // 1 + b*h
                y_next     = sat_add(FIX_ONE, prod);
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                // Diffusion term.
                x_next     = prod;
                state_next = ST_GROW_PREP;
            end
            ST_GROW_PREP:
            begin
                // 1 - G*(1 + b*h)
                y_next     = sat_sub(FIX_ONE, prod);
                state_next = ST_GROW;
            end
            ST_GROW:
            begin
                // Twice the square of the density.
                z_next     = sat_add(prod, prod);
                state_next = ST_GROW_WAIT;
            end
            ST_GROW_WAIT:
            begin
                state_next = ST_DP_SUM;
            end
            ST_DP_SUM:
            begin
                x_next     = sat_add(x_reg, prod);
                state_next = ST_DP_SUB;
            end
            ST_DP_SUB:
            begin
                x_next     = sat_sub(x_reg, z_reg);
                state_next = ST_DT;
            end
            ST_DT:
            begin
                state_next = ST_DT_WAIT;
            end
            ST_DT_WAIT:
            begin
                state_next = ST_NP;
            end
            ST_NP:
            begin
                // New density.
                x_next     = sat_add(job_reg.center_density, prod);
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                y_next     = floor_mean(job_reg.center_density, x_reg);
                state_next = ST_HIST;
            end
            ST_HIST:
            begin
                state_next = ST_HIST_WAIT;
            end
            ST_HIST_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_density_next = x_reg;
                    out_history_next = sat_add(job_reg.center_history, prod);
                    out_last_next    = job_reg.last;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg         <= job_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        z_reg           <= z_next;
        out_density_reg <= out_density_next;
        out_history_reg <= out_history_next;
        out_last_reg    <= out_last_next;
    end

    assign empty       = !out_valid_reg;
    assign new_density = out_density_reg;
    assign new_history = out_history_reg;
    assign last_out    = out_last_reg;

endmodule

/* design/euler_reaction_diffusion_step_1d.sv */
// Top level of the streaming explicit Euler reaction-diffusion step.
// Depends on erd_pkg, erd_front, erd_job_queue and erd_back.
//
//  Channel   Handshake              Payload
//  sites     push / full            site_density, site_history, last_site
//  results   empty / pop            new_density, new_history, last_out
//  config    cfg_write              cfg_index, cfg_data
//
// The back end works out each result through the seven products that share
// one two-stage multiplier, and takes no new job until the last is handed over.
// Sites are taken while the job queue has room; a last site that follows a
// held site makes two jobs and blocks the input until the second is queued.
// A result waits in the output register while the back end starts the next job.
// Reset clears the window, the queue and the output; no clearing pass is needed.
module euler_reaction_diffusion_step_1d
    import erd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  word_t                     site_density,
    input  word_t                     site_history,
    input  logic                      last_site,
    output logic                      empty,
    input  logic                      pop,
    output word_t                     new_density,
    output word_t                     new_history,
    output logic                      last_out,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_full, q_push, q_empty, q_pop;
    job_t q_job, q_head;

    // Configuration registers; unsigned ones keep their low 31 bits.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TIME_STEP:        cfg_next.time_step        = {1'b0, cfg_data[30:0]};
                REG_DECAY_GAIN:       cfg_next.decay_gain       = cfg_data;
                REG_HISTORY_COUPLING: cfg_next.history_coupling = cfg_data;
                REG_INV_DX_SQ:        cfg_next.inv_dx_sq        = {1'b0, cfg_data[30:0]};
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step        <= RST_TIME_STEP;
            cfg_reg.decay_gain       <= RST_DECAY_GAIN;
            cfg_reg.history_coupling <= RST_HISTORY_COUPLING;
            cfg_reg.inv_dx_sq        <= RST_INV_DX_SQ;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    erd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .site_density (site_density),
        .site_history (site_history),
        .last_site    (last_site),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_job)
    );

    erd_job_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_en  (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop_en   (q_pop),
        .head_job (q_head),
        .empty    (q_empty)
    );

    erd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .job_empty   (q_empty),
        .job         (q_head),
        .job_pop     (q_pop),
        .empty       (empty),
        .pop         (pop),
        .new_density (new_density),
        .new_history (new_history),
        .last_out    (last_out)
    );

endmodule

/* design/erd_checker.sv */
// Port-level checks of the reaction-diffusion step, bound to the top level.
// Depends on erd_pkg for the word type.
module erd_checker
    import erd_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  push,
    input logic  full,
    input logic  last_site,
    input logic  empty,
    input logic  pop,
    input word_t new_density,
    input word_t new_history,
    input logic  last_out
);

    logic       held_reg, held_next;
    logic [7:0] owed_reg, owed_next;
    logic       in_txn, out_txn;

    assign in_txn  = push && !full;
    assign out_txn = pop && !empty;

    // Shadow of the held site and of the results owed but not yet delivered.
    always_comb
    begin
        held_next = held_reg;
        owed_next = owed_reg;
        if (in_txn)
        begin
            held_next = !last_site;
            owed_next = owed_next + 8'(held_reg) + 8'(last_site);
        end
        if (out_txn)
        begin
            owed_next = owed_next - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
            owed_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
            owed_reg <= owed_next;
        end
    end

    // No result is shown right after reset.
    assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result shown right after reset");

    // A waiting result holds until its transaction completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(new_density) &&
                              $stable(new_history) && $stable(last_out)))
        else $error("waiting result changed before it was taken");

    // A last site after a held site makes two jobs, so input stalls once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_txn && last_site && held_reg) |=> full)
        else $error("input not stalled for second job of a row end");

    // A result appears only when one is owed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (owed_reg != 8'd0))
        else $error("result shown that no site caused");

endmodule

bind euler_reaction_diffusion_step_1d erd_checker u_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for the streaming Euler reaction-diffusion step.
// Depends on erd_pkg and euler_reaction_diffusion_step_1d; reads no files.
// A directed table and random lattice rows are checked against a local model.
module testbench;
    import erd_pkg::*;

    localparam int TOTAL_RANDOM_SITES = 550;
    localparam int STALL_LIMIT        = 3000;
    localparam int ROWS_PER_SETTING   = 8;
    localparam longint SAT_HI = longint'(WORD_MAX);
    localparam longint SAT_LO = longint'(WORD_MIN);
    localparam longint Q_ONE  = longint'(1) << FRAC_BITS;

    // One result transaction as it leaves the block.
    typedef struct packed {
        word_t density;
        word_t history;
        logic  last;
    } site_result_t;

    // One row of the directed table; typed rows carry their own expectation.
    typedef struct packed {
        word_t density;
        word_t history;
        logic  last;
        logic  typed;
        word_t exp_density;
        word_t exp_history;
    } site_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    word_t                     site_density;
    word_t                     site_history;
    logic                      last_site;
    logic                      empty;
    logic                      pop;
    word_t                     new_density;
    word_t                     new_history;
    logic                      last_out;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]       cfg_data;

    // Local copy of the window and the register file.
    longint window_left;
    longint window_center;
    longint window_history;
    logic   window_held;
    longint step_dt;
    longint gain_g;
    longint coupling_b;
    longint recip_dx2;

    site_result_t expected_results[$];
    site_result_t oldest_result;

    int send_idle;
    int recv_idle;
    int error_count;
    int results_checked;
    int sites_sent;
    int rows_sent;
    int settings_used;
    int stall_cycles;
    int row_len;
    int rows_since_setting;

    // Directed rows, all under the reset register values.
    site_row_t directed_rows [0:19] = '{
        '{32'sd0, 32'sd0, 1'b1, 1'b1, 32'sd0, 32'sd0},
        '{32'sd0, WORD_MAX, 1'b1, 1'b1, 32'sd0, WORD_MAX},
        '{32'sd0, WORD_MIN, 1'b1, 1'b1, 32'sd0, WORD_MIN},
        '{WORD_MAX, WORD_MAX, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{WORD_MIN, WORD_MIN, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{FIX_ONE, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{32'sh02000000, 32'sh00800000, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{32'sh00800000, -32'sd8388608, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{WORD_MAX, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{WORD_MIN, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{WORD_MAX, WORD_MIN, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{WORD_MIN, WORD_MAX, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{32'sh00400000, FIX_ONE, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{-32'sd4194304, -32'sd16777216, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{32'sh00100000, 32'sh00010000, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{32'sh01800000, 32'sh00200000, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{-32'sd25165824, 32'sh00400000, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{32'sh03000000, -32'sd2097152, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{32'sh00000001, 32'shFFFFFFFF, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{32'sh7F000000, 32'sh00000000, 1'b1, 1'b0, 32'sd0, 32'sd0}
    };

    euler_reaction_diffusion_step_1d i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .site_density (site_density),
        .site_history (site_history),
        .last_site    (last_site),
        .empty        (empty),
        .pop          (pop),
        .new_density  (new_density),
        .new_history  (new_history),
        .last_out     (last_out),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock with a period of 10.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Saturation to the word range.
    function automatic longint clamp_word(input longint x);
        if (x > SAT_HI)
            return SAT_HI;
        if (x < SAT_LO)
            return SAT_LO;
        return x;
    endfunction

    function automatic longint sum_sat(input longint a, input longint b);
        return clamp_word(a + b);
    endfunction

    function automatic longint diff_sat(input longint a, input longint b);
        return clamp_word(a - b);
    endfunction

    // Fixed-point product, floored by the arithmetic shift, then saturated.
    function automatic longint mul_q(input longint a, input longint b);
        return clamp_word((a * b) >>> FRAC_BITS);
    endfunction

    // Euler update of one site from its three-site window.
    function automatic site_result_t predict_site(input longint l, input longint c,
                                                  input longint h, input longint r,
                                                  input logic last);
        longint lap;
        longint diffusion;
        longint gain;
        longint growth;
        longint square;
        longint dp;
        longint np;
        longint mean;
        site_result_t res;
        lap       = diff_sat(sum_sat(l, r), sum_sat(c, c));
        diffusion = mul_q(lap, recip_dx2);
        gain      = mul_q(gain_g, sum_sat(Q_ONE, mul_q(coupling_b, h)));
        growth    = mul_q(diff_sat(Q_ONE, gain), c);
        square    = mul_q(c, c);
        dp        = diff_sat(sum_sat(diffusion, growth), sum_sat(square, square));
        np        = sum_sat(c, mul_q(step_dt, dp));
        // The mean of two words is exact in 64 bits; the shift floors it.
        mean      = (c + np) >>> 1;
        res.density = word_t'(np);
        res.history = word_t'(sum_sat(h, mul_q(mean, step_dt)));
        res.last    = last;
        return res;
    endfunction

    // Shift one site into the window and return the results it releases.
    function automatic int advance_window(input word_t p, input word_t h, input logic last,
                                          output site_result_t first_res,
                                          output site_result_t second_res);
        int n;
        n = 0;
        first_res  = '0;
        second_res = '0;
        if (window_held)
        begin
            first_res   = predict_site(window_left, window_center, window_history,
                                       longint'(p), 1'b0);
            n           = 1;
            window_left = window_center;
        end
        else
        begin
            window_left = 0;
        end
        window_center  = longint'(p);
        window_history = longint'(h);
        window_held    = 1'b1;
        if (last)
        begin
            if (n == 0)
                first_res = predict_site(window_left, window_center, window_history, 0, 1'b1);
            else
                second_res = predict_site(window_left, window_center, window_history, 0, 1'b1);
            n              = n + 1;
            window_left    = 0;
            window_center  = 0;
            window_history = 0;
            window_held    = 1'b0;
        end
        return n;
    endfunction

    // Random word: usually a moderate value, sometimes an extreme or any pattern.
    function automatic word_t rand_word(input int span_bits);
        int pick;
        longint span;
        pick = $urandom_range(99);
        span = longint'(1) << span_bits;
        if (pick < 70)
            return word_t'(longint'($urandom_range(0, 2 * span)) - span);
        if (pick < 85)
            return word_t'($urandom);
        case ($urandom_range(4))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return FIX_ONE;
            3: return -FIX_ONE;
            default: return '0;
        endcase
    endfunction

    // Offer one site transaction and record what it is expected to produce.
    task automatic send_site(input word_t p, input word_t h, input logic last,
                             input logic typed, input word_t exp_p, input word_t exp_h);
        site_result_t first_res;
        site_result_t second_res;
        int n;
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push         <= 1'b1;
        site_density <= p;
        site_history <= h;
        last_site    <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        n = advance_window(p, h, last, first_res, second_res);
        if (typed)
        begin
            first_res.density = exp_p;
            first_res.history = exp_h;
            first_res.last    = 1'b1;
        end
        if (n > 0)
            expected_results.insert(expected_results.size(), first_res);
        if (n > 1)
            expected_results.insert(expected_results.size(), second_res);
        sites_sent = sites_sent + 1;
        if (last)
            rows_sent = rows_sent + 1;
        @(negedge clk);
    endtask

    // Let the block run dry before the registers change.
    task automatic wait_idle();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register and mirror it in the local register file.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_TIME_STEP:        step_dt    = longint'(value[30:0]);
            REG_DECAY_GAIN:       gain_g     = longint'($signed(value));
            REG_HISTORY_COUPLING: coupling_b = longint'($signed(value));
            REG_INV_DX_SQ:        recip_dx2  = longint'(value[30:0]);
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Pick the next register setting: both extremes first, then random ones.
    task automatic apply_setting();
        logic [CFG_BITS-1:0] dt_val;
        logic [CFG_BITS-1:0] gain_val;
        logic [CFG_BITS-1:0] coupling_val;
        logic [CFG_BITS-1:0] recip_val;
        if (settings_used == 0)
        begin
            dt_val       = 32'hFFFF_FFFF;
            gain_val     = WORD_MAX;
            coupling_val = WORD_MAX;
            recip_val    = 32'hFFFF_FFFF;
        end
        else if (settings_used == 1)
        begin
            dt_val       = '0;
            gain_val     = WORD_MIN;
            coupling_val = WORD_MIN;
            recip_val    = '0;
        end
        else
        begin
            dt_val       = $urandom_range(0, 1 << 24);
            gain_val     = int'($urandom_range(0, 1 << 26)) - (1 << 25);
            coupling_val = int'($urandom_range(0, 1 << 24)) - (1 << 23);
            recip_val    = $urandom_range(0, 1 << 26);
            if ($urandom_range(3) == 0)
                dt_val = $urandom;
            if ($urandom_range(3) == 0)
                gain_val = $urandom;
            if ($urandom_range(3) == 0)
                coupling_val = $urandom;
            if ($urandom_range(3) == 0)
                recip_val = $urandom;
        end
        write_reg(REG_TIME_STEP, dt_val);
        write_reg(REG_DECAY_GAIN, gain_val);
        write_reg(REG_HISTORY_COUPLING, coupling_val);
        write_reg(REG_INV_DX_SQ, recip_val);
        cfg_write <= 1'b0;
        settings_used = settings_used + 1;
    endtask

    // Result side: random stalls, then compare each accepted transaction.
    always @(negedge clk)
    begin
        if (rst_n)
            pop <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected: density %0d history %0d",
                       new_density, new_history);
                error_count = error_count + 1;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (new_density !== oldest_result.density)
                begin
                    $error("new_density: expected %0d, got %0d",
                           oldest_result.density, new_density);
                    error_count = error_count + 1;
                end
                if (new_history !== oldest_result.history)
                begin
                    $error("new_history: expected %0d, got %0d",
                           oldest_result.history, new_history);
                    error_count = error_count + 1;
                end
                if (last_out !== oldest_result.last)
                begin
                    $error("last_out: expected %0b, got %0b", oldest_result.last, last_out);
                    error_count = error_count + 1;
                end
                results_checked = results_checked + 1;
            end
        end
    end

    // Watchdog: too long without any accepted transaction ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random rows, drain.
    initial
    begin
        rst_n              = 1'b0;
        push               = 1'b0;
        pop                = 1'b0;
        site_density       = '0;
        site_history       = '0;
        last_site          = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = REG_TIME_STEP;
        cfg_data           = '0;
        window_left        = 0;
        window_center      = 0;
        window_history     = 0;
        window_held        = 1'b0;
        step_dt            = longint'(RST_TIME_STEP);
        gain_g             = longint'(RST_DECAY_GAIN);
        coupling_b         = longint'(RST_HISTORY_COUPLING);
        recip_dx2          = longint'(RST_INV_DX_SQ);
        send_idle          = 13;
        recv_idle          = 54;
        error_count        = 0;
        results_checked    = 0;
        sites_sent         = 0;
        rows_sent          = 0;
        settings_used      = 0;
        stall_cycles       = 0;
        rows_since_setting = ROWS_PER_SETTING;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table under the reset register values.
        foreach (directed_rows[i])
            send_site(directed_rows[i].density, directed_rows[i].history,
                      directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].exp_density, directed_rows[i].exp_history);

        // Random rows; stall pattern changes by thirds of the run.
        while (sites_sent < TOTAL_RANDOM_SITES + 20)
        begin
            if (sites_sent < 20 + TOTAL_RANDOM_SITES / 3)
            begin
                send_idle = 13;
                recv_idle = 54;
            end
            else if (sites_sent < 20 + 2 * TOTAL_RANDOM_SITES / 3)
            begin
                send_idle = 54;
                recv_idle = 13;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (rows_since_setting >= ROWS_PER_SETTING)
            begin
                wait_idle();
                apply_setting();
                rows_since_setting = 0;
            end
            if ($urandom_range(4) == 0)
                row_len = $urandom_range(9, 24);
            else
                row_len = $urandom_range(1, 8);
            for (int k = 0; k < row_len; k++)
                send_site(rand_word(26), rand_word(25), k == row_len - 1, 1'b0, '0, '0);
            rows_since_setting = rows_since_setting + 1;
        end
        push <= 1'b0;

        // Drain, then give the back end time to show any stray result.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Run covered %0d sites in %0d rows under %0d register settings.",
                 sites_sent, rows_sent, settings_used + 1);
        $display("%0d result transactions compared, %0d mismatches.",
                 results_checked, error_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
